@@ rtl/core/ntd_pkg.sv @@
`default_nettype none
package ntd_pkg;

  localparam int MAX_PIXELS = 131072;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int POS_W      = 96;

  // square root: 32 result bits, two per stage
  localparam int SQ_STAGES = 16;
  localparam int SQ_SPS    = 2;
  // angle divider: 63 quotient bits, three per stage
  localparam int DA_STAGES = 21;
  localparam int DA_SPS    = 3;
  // d-spacing divider: 32 quotient bits, two per stage
  localparam int DD_STAGES = 16;
  localparam int DD_SPS    = 2;

  typedef enum logic [1:0] {
    CFG_PIXEL_COUNT = 2'd0,
    CFG_WAVELENGTH  = 2'd1,
    CFG_SOURCE_DIST = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // sideband that travels with an event through the arithmetic units
  typedef struct packed {
    logic [31:0]        pid;
    logic [31:0]        ch;
    logic signed [31:0] x;
    logic [31:0]        r;
    logic [63:0]        den;
    logic               oor;
    logic               sat;
  } carry_t;

endpackage
`default_nettype wire

@@ rtl/core/neutron_event_to_d_spacing_unit.sv @@
// Neutron event to d-spacing converter.
// Input channel (in_valid/in_ready): op selects convert event or load pixel
// position. A load writes one entry of the position table in the cycle of its
// transfer and gives no result; a convert issued in the next cycle already
// sees it. Software loads the table before events for those pixels arrive.
// Output channel (out_valid/out_ready): one result per convert, in order.
// Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
// Pipeline registers from input transfer to out_valid: table read, squares
// and sum, square root, angle setup, angle divider, square root, products
// and range check, d divider, output register.
// Throughput: one item per cycle while out_ready is high; every stage is a
// pipeline register with its own valid, so bubbles collapse in a stall.
// Stall: the result holds on the outputs; the pipeline keeps filling until
// it is full, then in_ready drops.
// Reset: pipeline valids and config registers clear; the position table
// is not cleared and holds undefined data until loaded.
`default_nettype none
module neutron_event_to_d_spacing_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] pixel_id,
  input  logic [31:0] tof_channel,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic [31:0] d_spacing,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [17:0] pixel_count;
  logic [39:0] wavelength_per_channel;
  logic [31:0] source_to_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count            <= '0;
      wavelength_per_channel <= '0;
      source_to_sample       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ntd_pkg::CFG_PIXEL_COUNT: pixel_count            <= cfg_data[17:0];
        ntd_pkg::CFG_WAVELENGTH:  wavelength_per_channel <= cfg_data;
        ntd_pkg::CFG_SOURCE_DIST: source_to_sample       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  logic en_a, en_b, en_c, en_d, en_e1, en_e2, en_e3, en_e4, en_o;
  logic a_v, b_v, c_v, d_v, e1_v, e2_v, e3_v, e4_v, o_v;
  logic sq1_in_ready, sq1_out_valid, da_in_ready, da_out_valid;
  logic sq2_in_ready, sq2_out_valid, dd_in_ready, dd_out_valid;

  ntd_pkg::carry_t a_c, b_c, c_c, d_c, e1_c, e2_c, e3_c, e4_c;
  ntd_pkg::carry_t sq1_c, da_c, sq2_c, dd_c;
  ntd_pkg::carry_t a_in, b_in, d_in, e1_in, e4_in;

  logic [95:0] pos_rd;
  logic [31:0] sq1_root, sq2_root, dd_quot;
  logic [62:0] da_quot;

  assign en_o  = !o_v || out_ready;
  assign en_e4 = !e4_v || dd_in_ready;
  assign en_e3 = !e3_v || en_e4;
  assign en_e2 = !e2_v || en_e3;
  assign en_e1 = !e1_v || en_e2;
  assign en_d  = !d_v || da_in_ready;
  assign en_c  = !c_v || sq1_in_ready;
  assign en_b  = !b_v || en_c;
  assign en_a  = !a_v || en_b;
  assign in_ready = en_a;

  logic xfer, conv, load;
  assign xfer = in_valid && en_a;
  assign conv = xfer && !op;
  assign load = xfer && op && (pixel_id < 32'(ntd_pkg::MAX_PIXELS));

  // one transfer per cycle, so a load and a read never hit the same edge
  ntd_ram #(
    .WIDTH(ntd_pkg::POS_W),
    .DEPTH(ntd_pkg::MAX_PIXELS)
  ) u_pos_ram (
    .clk  (clk),
    .we   (load),
    .waddr(pixel_id[ntd_pkg::PIX_AW-1:0]),
    .wdata({pos_x, pos_y, pos_z}),
    .re   (conv),
    .raddr(pixel_id[ntd_pkg::PIX_AW-1:0]),
    .rdata(pos_rd)
  );

  always_comb begin
    a_in     = '0;
    a_in.pid = pixel_id;
    a_in.ch  = tof_channel;
    a_in.oor = (pixel_id >= {14'd0, pixel_count})
            || (pixel_id >= 32'(ntd_pkg::MAX_PIXELS));
  end

  // stage B: squares of the magnitudes
  logic [31:0] mx, my, mz;
  logic [63:0] b_sx, b_sy, b_sz, c_sum;
  assign mx = mag(pos_rd[95:64]);
  assign my = mag(pos_rd[63:32]);
  assign mz = mag(pos_rd[31:0]);

  always_comb begin
    b_in   = a_c;
    b_in.x = pos_rd[95:64];
  end

  // stage D: r - x and the zero angle check
  logic [33:0] d_diff;
  logic [31:0] d_num_hi;
  logic [1:0]  d_num_lo;
  assign d_diff = {2'b00, sq1_root} - {{2{sq1_c.x[31]}}, sq1_c.x};

  always_comb begin
    d_in     = sq1_c;
    d_in.r   = sq1_root;
    d_in.sat = (sq1_root == 32'd0) || d_diff[33] || (d_diff == 34'd0);
  end

  // stage E1: denominator (L1 + r) * k
  logic [32:0] e1_base;
  logic [64:0] e1_prod;
  assign e1_base = {1'b0, source_to_sample} + {1'b0, sq2_c.r};
  assign e1_prod = {32'd0, e1_base} * {33'd0, sq2_root};
  always_comb begin
    e1_in     = sq2_c;
    e1_in.den = e1_prod[63:0];
  end

  // stages E2/E3: channel * wavelength in two partial products
  logic [51:0] e2_plo_w, e2_plo, e3_phi_w;
  logic [71:0] e3_prod_w, e3_prod, e4_prod;
  assign e2_plo_w  = {20'd0, e1_c.ch} * {32'd0, wavelength_per_channel[19:0]};
  assign e3_phi_w  = {20'd0, e2_c.ch} * {32'd0, wavelength_per_channel[39:20]};
  assign e3_prod_w = {e3_phi_w, 20'd0} + {20'd0, e2_plo};

  // stage E4: quotient above 32 bits or zero denominator saturates
  logic e4_ovf;
  assign e4_ovf = ({2'b00, e3_prod[71:10]} >= e3_c.den);
  always_comb begin
    e4_in     = e3_c;
    e4_in.sat = e3_c.sat || e4_ovf || (e3_c.den == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      c_v  <= 1'b0;
      d_v  <= 1'b0;
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      e4_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (en_a)  a_v  <= conv;
      if (en_b)  b_v  <= a_v;
      if (en_c)  c_v  <= b_v;
      if (en_d)  d_v  <= sq1_out_valid;
      if (en_e1) e1_v <= sq2_out_valid;
      if (en_e2) e2_v <= e1_v;
      if (en_e3) e3_v <= e2_v;
      if (en_e4) e4_v <= e3_v;
      if (en_o)  o_v  <= dd_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) a_c <= a_in;
    if (en_b) begin
      b_c   <= b_in;
      b_sx  <= {32'd0, mx} * {32'd0, mx};
      b_sy  <= {32'd0, my} * {32'd0, my};
      b_sz  <= {32'd0, mz} * {32'd0, mz};
    end
    if (en_c) begin
      c_c   <= b_c;
      c_sum <= b_sx + b_sy + b_sz;
    end
    if (en_d) begin
      d_c      <= d_in;
      d_num_hi <= d_diff[33:2];
      d_num_lo <= d_diff[1:0];
    end
    if (en_e1) e1_c <= e1_in;
    if (en_e2) begin
      e2_c   <= e1_c;
      e2_plo <= e2_plo_w;
    end
    if (en_e3) begin
      e3_c    <= e2_c;
      e3_prod <= e3_prod_w;
    end
    if (en_e4) begin
      e4_c    <= e4_in;
      e4_prod <= e3_prod;
    end
    if (en_o) begin
      out_pixel <= dd_c.pid;
      if (dd_c.oor) begin
        d_spacing <= 32'd0;
        status    <= ntd_pkg::ST_RANGE;
      end else if (dd_c.sat) begin
        d_spacing <= 32'hFFFF_FFFF;
        status    <= ntd_pkg::ST_SAT;
      end else begin
        d_spacing <= dd_quot;
        status    <= ntd_pkg::ST_OK;
      end
    end
  end

  assign out_valid = o_v;

  ntd_sqrt u_sqrt_r (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_v),
    .in_ready (sq1_in_ready),
    .rad      (c_sum),
    .in_carry (c_c),
    .out_valid(sq1_out_valid),
    .out_ready(en_d),
    .root     (sq1_root),
    .out_carry(sq1_c)
  );

  ntd_div_angle u_div_angle (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_v),
    .in_ready (da_in_ready),
    .num_hi   (d_num_hi),
    .num_lo   (d_num_lo),
    .in_carry (d_c),
    .out_valid(da_out_valid),
    .out_ready(sq2_in_ready),
    .quot     (da_quot),
    .out_carry(da_c)
  );

  ntd_sqrt u_sqrt_k (
    .clk      (clk),
    .rst      (rst),
    .in_valid (da_out_valid),
    .in_ready (sq2_in_ready),
    .rad      ({1'b0, da_quot}),
    .in_carry (da_c),
    .out_valid(sq2_out_valid),
    .out_ready(en_e1),
    .root     (sq2_root),
    .out_carry(sq2_c)
  );

  ntd_div_dspace u_div_dspace (
    .clk      (clk),
    .rst      (rst),
    .in_valid (e4_v),
    .in_ready (dd_in_ready),
    .rem_init ({2'b00, e4_prod[71:10]}),
    .bits_init({e4_prod[9:0], 22'd0}),
    .in_carry (e4_c),
    .out_valid(dd_out_valid),
    .out_ready(en_o),
    .quot     (dd_quot),
    .out_carry(dd_c)
  );

endmodule
`default_nettype wire

@@ rtl/core/ntd_ram.sv @@
`default_nettype none
module ntd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/ntd_sqrt.sv @@
`default_nettype none
module ntd_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [63:0]     rad,
  input  ntd_pkg::carry_t in_carry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     root,
  output ntd_pkg::carry_t out_carry
);

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  function automatic sq_t sq_stage(sq_t s);
    sq_t         t;
    logic [34:0] rem2;
    logic [34:0] trial;
    int          i;
    t = s;
    for (i = 0; i < ntd_pkg::SQ_SPS; i++) begin
      rem2  = {t.rem[32:0], t.rad[63:62]};
      trial = {1'b0, t.root, 2'b01};
      if (rem2 >= trial) begin
        t.rem  = rem2 - trial;
        t.root = {t.root[30:0], 1'b1};
      end else begin
        t.rem  = rem2;
        t.root = {t.root[30:0], 1'b0};
      end
      t.rad = {t.rad[61:0], 2'b00};
    end
    return t;
  endfunction

  sq_t                        st [ntd_pkg::SQ_STAGES];
  sq_t                        nx [ntd_pkg::SQ_STAGES];
  ntd_pkg::carry_t            cr [ntd_pkg::SQ_STAGES];
  logic [ntd_pkg::SQ_STAGES-1:0] v;
  logic [ntd_pkg::SQ_STAGES:0]   en;

  always_comb begin
    en[ntd_pkg::SQ_STAGES] = out_ready;
    for (int j = ntd_pkg::SQ_STAGES - 1; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  always_comb begin
    for (int j = 0; j < ntd_pkg::SQ_STAGES; j++) begin
      if (j == 0) nx[j] = sq_stage('{rem: '0, root: '0, rad: rad});
      else nx[j] = sq_stage(st[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < ntd_pkg::SQ_STAGES; j++) begin
        if (en[j]) begin
          if (j == 0) v[j] <= in_valid;
          else v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ntd_pkg::SQ_STAGES; j++) begin
      if (en[j]) begin
        st[j] <= nx[j];
        if (j == 0) cr[j] <= in_carry;
        else cr[j] <= cr[j-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[ntd_pkg::SQ_STAGES-1];
  assign root      = st[ntd_pkg::SQ_STAGES-1].root;
  assign out_carry = cr[ntd_pkg::SQ_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/core/ntd_div_angle.sv @@
`default_nettype none
module ntd_div_angle (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     num_hi,
  input  logic [1:0]      num_lo,
  input  ntd_pkg::carry_t in_carry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [62:0]     quot,
  output ntd_pkg::carry_t out_carry
);

  typedef struct packed {
    logic [31:0] rem;
    logic [62:0] q;
    logic [62:0] bits;
  } da_t;

  // divisor is the distance r carried with the event
  function automatic da_t da_stage(da_t s, logic [31:0] d);
    da_t         t;
    logic [32:0] rem2;
    int          i;
    t = s;
    for (i = 0; i < ntd_pkg::DA_SPS; i++) begin
      rem2 = {t.rem, t.bits[62]};
      if (rem2 >= {1'b0, d}) begin
        rem2 = rem2 - {1'b0, d};
        t.q  = {t.q[61:0], 1'b1};
      end else begin
        t.q  = {t.q[61:0], 1'b0};
      end
      t.rem  = rem2[31:0];
      t.bits = {t.bits[61:0], 1'b0};
    end
    return t;
  endfunction

  da_t                           st [ntd_pkg::DA_STAGES];
  da_t                           nx [ntd_pkg::DA_STAGES];
  ntd_pkg::carry_t               cr [ntd_pkg::DA_STAGES];
  logic [ntd_pkg::DA_STAGES-1:0] v;
  logic [ntd_pkg::DA_STAGES:0]   en;

  always_comb begin
    en[ntd_pkg::DA_STAGES] = out_ready;
    for (int j = ntd_pkg::DA_STAGES - 1; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  always_comb begin
    for (int j = 0; j < ntd_pkg::DA_STAGES; j++) begin
      if (j == 0) nx[j] = da_stage('{rem: num_hi, q: '0, bits: {num_lo, 61'd0}}, in_carry.r);
      else nx[j] = da_stage(st[j-1], cr[j-1].r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < ntd_pkg::DA_STAGES; j++) begin
        if (en[j]) begin
          if (j == 0) v[j] <= in_valid;
          else v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ntd_pkg::DA_STAGES; j++) begin
      if (en[j]) begin
        st[j] <= nx[j];
        if (j == 0) cr[j] <= in_carry;
        else cr[j] <= cr[j-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[ntd_pkg::DA_STAGES-1];
  assign quot      = st[ntd_pkg::DA_STAGES-1].q;
  assign out_carry = cr[ntd_pkg::DA_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/core/ntd_div_dspace.sv @@
`default_nettype none
module ntd_div_dspace (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [63:0]     rem_init,
  input  logic [31:0]     bits_init,
  input  ntd_pkg::carry_t in_carry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     quot,
  output ntd_pkg::carry_t out_carry
);

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] q;
    logic [31:0] bits;
  } dd_t;

  // divisor is the denominator carried with the event
  function automatic dd_t dd_stage(dd_t s, logic [63:0] d);
    dd_t         t;
    logic [64:0] rem2;
    int          i;
    t = s;
    for (i = 0; i < ntd_pkg::DD_SPS; i++) begin
      rem2 = {t.rem, t.bits[31]};
      if (rem2 >= {1'b0, d}) begin
        rem2 = rem2 - {1'b0, d};
        t.q  = {t.q[30:0], 1'b1};
      end else begin
        t.q  = {t.q[30:0], 1'b0};
      end
      t.rem  = rem2[63:0];
      t.bits = {t.bits[30:0], 1'b0};
    end
    return t;
  endfunction

  dd_t                           st [ntd_pkg::DD_STAGES];
  dd_t                           nx [ntd_pkg::DD_STAGES];
  ntd_pkg::carry_t               cr [ntd_pkg::DD_STAGES];
  logic [ntd_pkg::DD_STAGES-1:0] v;
  logic [ntd_pkg::DD_STAGES:0]   en;

  always_comb begin
    en[ntd_pkg::DD_STAGES] = out_ready;
    for (int j = ntd_pkg::DD_STAGES - 1; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  always_comb begin
    for (int j = 0; j < ntd_pkg::DD_STAGES; j++) begin
      if (j == 0) nx[j] = dd_stage('{rem: rem_init, q: '0, bits: bits_init}, in_carry.den);
      else nx[j] = dd_stage(st[j-1], cr[j-1].den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < ntd_pkg::DD_STAGES; j++) begin
        if (en[j]) begin
          if (j == 0) v[j] <= in_valid;
          else v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ntd_pkg::DD_STAGES; j++) begin
      if (en[j]) begin
        st[j] <= nx[j];
        if (j == 0) cr[j] <= in_carry;
        else cr[j] <= cr[j-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[ntd_pkg::DD_STAGES-1];
  assign quot      = st[ntd_pkg::DD_STAGES-1].q;
  assign out_carry = cr[ntd_pkg::DD_STAGES-1];

endmodule
`default_nettype wire
